// ===== rtl/fdp_pkg.sv =====
// Package for the firmware download engine: result events, phases, bundle
// and context structs, register indexes and protocol byte codes.
// No dependencies.
`default_nettype none

package fdp_pkg;

  localparam int unsigned ChunkBytes = 1024;
  localparam int unsigned CntW       = $clog2(ChunkBytes) + 1;

  // configuration register indexes
  localparam logic RegUpdateReq = 1'b0;
  localparam logic RegMark      = 1'b1;

  // request word values
  localparam logic [31:0] ReqUpdate = 32'h5555_5555;
  localparam logic [31:0] ReqWait   = 32'hFFFF_FFFF;

  // link bytes
  localparam logic [7:0] BSession = 8'h10;
  localparam logic [7:0] BSessAck = 8'h20;
  localparam logic [7:0] BProbe   = 8'h55;
  localparam logic [7:0] BProbeAk = 8'hAA;
  localparam logic [7:0] BNack    = 8'h7F;
  localparam logic [7:0] BDload   = 8'h34;
  localparam logic [7:0] BDlAck   = 8'h30;
  localparam logic [7:0] BHdrAck  = 8'h44;
  localparam logic [7:0] BChunk   = 8'h36;
  localparam logic [7:0] BChAck   = 8'h38;
  localparam logic [7:0] BChDone  = 8'h46;
  localparam logic [7:0] BExit    = 8'h37;
  localparam logic [7:0] BExitAck = 8'h47;

  // result kinds
  localparam logic [1:0] KindTx    = 2'd0;
  localparam logic [1:0] KindErase = 2'd1;
  localparam logic [1:0] KindProg  = 2'd2;
  localparam logic [1:0] KindReset = 2'd3;

  localparam int unsigned TdataW = 80;

  typedef enum logic [4:0] {
    PH_SESSION  = 5'b00001,
    PH_DOWNLOAD = 5'b00010,
    PH_TRANSFER = 5'b00100,
    PH_EXIT     = 5'b01000,
    PH_DONE     = 5'b10000
  } phase_e;

  // what sequence of results one input item produces
  typedef enum logic [2:0] {
    EV_SEND  = 3'd0,  // one tx byte
    EV_SKIP  = 3'd1,  // 0x20, erase 1
    EV_HDR   = 3'd2,  // 0x44, erase 2..5
    EV_EMPTY = 3'd3,  // 0x38, 0x46
    EV_PROG  = 3'd4,  // program word, optionally 0x46
    EV_EXIT  = 3'd5   // 0x47, erase 1, three mark words, reset
  } ev_e;

  typedef struct packed {
    ev_e         ev;
    logic [2:0]  n;      // result count, 0 = none
    logic [7:0]  tx;
    logic [31:0] addr;
    logic [31:0] data;
  } bundle_t;

  typedef struct packed {
    logic [31:0] mark;
    logic [31:0] first;
    logic [31:0] entry;
    logic [31:0] size;
  } ctx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [2:0]  sector;
    logic [31:0] addr;
    logic [31:0] data;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/fdp_core.sv =====
// Protocol state and per-beat decode of the download engine.
// Depends on fdp_pkg.
`default_nettype none

module fdp_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_mode_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic [31:0]       req_word_i,
  input  wire logic [31:0]       mark_i,
  input  wire logic              free_i,
  output logic                   fire_o,
  output logic                   load_o,
  output fdp_pkg::bundle_t       bundle_o,
  output fdp_pkg::ctx_t          ctx_o
);

  fdp_pkg::phase_e phase_q, phase_d;
  logic sub_q, sub_d;
  logic [3:0] hc_q, hc_d;
  logic [31:0] hs_q, hs_d;
  logic [31:0] entry_q, entry_d, size_q, size_d, first_q, first_d;
  logic [31:0] rem_q, rem_d, pa_q, pa_d;
  logic [fdp_pkg::CntW-1:0] cc_q, cc_d;
  logic [23:0] wa_q, wa_d;
  logic [1:0] lane_q, lane_d;

  fdp_pkg::bundle_t bd;
  logic [fdp_pkg::CntW-1:0] len, cc_inc;
  logic [31:0] word, rem_sub, hs_new;
  logic [3:0] hc_inc;
  logic chunk_end;

  always_comb begin
    if (rem_q != 32'd0 && rem_q <= 32'(fdp_pkg::ChunkBytes)) begin
      len = rem_q[fdp_pkg::CntW-1:0];
    end else begin
      len = fdp_pkg::CntW'(fdp_pkg::ChunkBytes);
    end
    cc_inc    = cc_q + 1'b1;
    chunk_end = cc_inc >= len;
    rem_sub   = (rem_q > 32'(len)) ? rem_q - 32'(len) : 32'd0;
    hs_new    = {hs_q[23:0], in_byte_i};
    hc_inc    = hc_q + 4'd1;
    case (lane_q)
      2'd0:    word = {24'd0, in_byte_i};
      2'd1:    word = {8'd0, wa_q} | {16'd0, in_byte_i, 8'd0};
      2'd2:    word = {8'd0, wa_q} | {8'd0, in_byte_i, 16'd0};
      default: word = {in_byte_i, wa_q};
    endcase
  end

  always_comb begin
    phase_d = phase_q;  sub_d = sub_q;     hc_d = hc_q;     hs_d = hs_q;
    entry_d = entry_q;  size_d = size_q;   first_d = first_q;
    rem_d   = rem_q;    pa_d = pa_q;       cc_d = cc_q;     wa_d = wa_q;
    lane_d  = lane_q;
    bd      = '{ev: fdp_pkg::EV_SEND, n: 3'd0, tx: 8'd0, addr: 32'd0, data: 32'd0};

    unique case (phase_q)
      fdp_pkg::PH_SESSION: begin
        if (req_word_i == fdp_pkg::ReqUpdate) begin
          bd.ev = fdp_pkg::EV_SKIP;  bd.n = 3'd2;
          phase_d = fdp_pkg::PH_DOWNLOAD;  sub_d = 1'b0;
        end else if (in_mode_i && req_word_i == fdp_pkg::ReqWait) begin
          bd.n = 3'd1;
          if (in_byte_i == fdp_pkg::BSession) begin
            bd.tx = fdp_pkg::BSessAck;
            phase_d = fdp_pkg::PH_DOWNLOAD;  sub_d = 1'b0;
          end else if (in_byte_i == fdp_pkg::BProbe) begin
            bd.tx = fdp_pkg::BProbeAk;
          end else begin
            bd.tx = fdp_pkg::BNack;  sub_d = 1'b0;
          end
        end
      end
      fdp_pkg::PH_DOWNLOAD: begin
        if (in_mode_i) begin
          if (!sub_q) begin
            bd.n = 3'd1;
            if (in_byte_i == fdp_pkg::BDload) begin
              bd.tx = fdp_pkg::BDlAck;
              sub_d = 1'b1;  hc_d = 4'd0;  hs_d = 32'd0;
            end else begin
              bd.tx = fdp_pkg::BNack;
              phase_d = fdp_pkg::PH_SESSION;  sub_d = 1'b0;
            end
          end else begin
            hs_d = hs_new;
            hc_d = hc_inc;
            if (hc_inc == 4'd4) begin
              entry_d = hs_new;
            end else if (hc_inc == 4'd8) begin
              size_d = hs_new;
            end else if (hc_inc >= 4'd12) begin
              first_d = hs_new;  rem_d = size_q;  pa_d = hs_new;  hc_d = 4'd0;
              bd.ev = fdp_pkg::EV_HDR;  bd.n = 3'd5;
              phase_d = fdp_pkg::PH_TRANSFER;  sub_d = 1'b0;
            end
          end
        end
      end
      fdp_pkg::PH_TRANSFER: begin
        if (in_mode_i) begin
          if (!sub_q) begin
            if (in_byte_i == fdp_pkg::BChunk) begin
              if (rem_q == 32'd0) begin
                bd.ev = fdp_pkg::EV_EMPTY;  bd.n = 3'd2;
                phase_d = fdp_pkg::PH_EXIT;
              end else begin
                bd.n = 3'd1;  bd.tx = fdp_pkg::BChAck;
                sub_d = 1'b1;  cc_d = '0;  lane_d = 2'd0;  wa_d = 24'd0;
              end
            end else begin
              bd.n = 3'd1;  bd.tx = fdp_pkg::BNack;
              phase_d = fdp_pkg::PH_SESSION;  sub_d = 1'b0;
            end
          end else begin
            cc_d = cc_inc;
            if (lane_q == 2'd3 || chunk_end) begin
              bd.ev = fdp_pkg::EV_PROG;  bd.n = 3'd1;
              bd.addr = pa_q;  bd.data = word;
              pa_d = pa_q + 32'd4;  wa_d = 24'd0;  lane_d = 2'd0;
            end else begin
              wa_d = word[23:0];  lane_d = lane_q + 2'd1;
            end
            if (chunk_end) begin
              bd.n = 3'd2;
              rem_d = rem_sub;  cc_d = '0;  sub_d = 1'b0;
              if (rem_sub == 32'd0) phase_d = fdp_pkg::PH_EXIT;
            end
          end
        end
      end
      fdp_pkg::PH_EXIT: begin
        if (in_mode_i) begin
          if (in_byte_i == fdp_pkg::BExit) begin
            bd.ev = fdp_pkg::EV_EXIT;  bd.n = 3'd6;
            phase_d = fdp_pkg::PH_DONE;
          end else begin
            bd.n = 3'd1;  bd.tx = fdp_pkg::BNack;
            phase_d = fdp_pkg::PH_SESSION;  sub_d = 1'b0;
          end
        end
      end
      fdp_pkg::PH_DONE: begin
        // frozen until reset
      end
      default: begin
        phase_d = fdp_pkg::PH_SESSION;
      end
    endcase
  end

  // results go to the drainer; a beat with none needs no free slot
  assign fire_o   = in_valid_i && (bd.n == 3'd0 || free_i);
  assign load_o   = fire_o && bd.n != 3'd0;
  assign bundle_o = bd;
  assign ctx_o    = '{mark: mark_i, first: first_q, entry: entry_q, size: size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fdp_pkg::PH_SESSION;
      sub_q   <= 1'b0;
      hc_q    <= 4'd0;
      hs_q    <= 32'd0;
      entry_q <= 32'd0;
      size_q  <= 32'd0;
      first_q <= 32'd0;
      rem_q   <= 32'd0;
      pa_q    <= 32'd0;
      cc_q    <= '0;
      wa_q    <= 24'd0;
      lane_q  <= 2'd0;
    end else if (fire_o) begin
      phase_q <= phase_d;
      sub_q   <= sub_d;
      hc_q    <= hc_d;
      hs_q    <= hs_d;
      entry_q <= entry_d;
      size_q  <= size_d;
      first_q <= first_d;
      rem_q   <= rem_d;
      pa_q    <= pa_d;
      cc_q    <= cc_d;
      wa_q    <= wa_d;
      lane_q  <= lane_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fdp_drain.sv =====
// Result register of the download engine: holds one beat's results and
// hands them out one per cycle while ready_i is high. Depends on fdp_pkg.
`default_nettype none

module fdp_drain (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire fdp_pkg::bundle_t            bundle_i,
  input  wire fdp_pkg::ctx_t               ctx_i,
  output logic                             free_o,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [fdp_pkg::TdataW-1:0]       data_o,
  output logic [1:0]                       user_o,
  output logic                             last_o
);

  logic             bv_q;
  logic [2:0]       idx_q;
  fdp_pkg::bundle_t bd_q;
  fdp_pkg::result_t res;
  logic             is_last, take;

  assign is_last = idx_q == (bd_q.n - 3'd1);
  assign take    = bv_q && ready_i;
  assign free_o  = !bv_q || (take && is_last);

  always_comb begin
    res = '{kind: fdp_pkg::KindTx, tx: 8'd0, sector: 3'd0, addr: 32'd0, data: 32'd0};
    case (bd_q.ev)
      fdp_pkg::EV_SEND: begin
        res.tx = bd_q.tx;
      end
      fdp_pkg::EV_SKIP: begin
        if (idx_q == 3'd0) begin
          res.tx = fdp_pkg::BSessAck;
        end else begin
          res.kind = fdp_pkg::KindErase;  res.sector = 3'd1;
        end
      end
      fdp_pkg::EV_HDR: begin
        if (idx_q == 3'd0) begin
          res.tx = fdp_pkg::BHdrAck;
        end else begin
          res.kind = fdp_pkg::KindErase;  res.sector = idx_q + 3'd1;
        end
      end
      fdp_pkg::EV_EMPTY: begin
        res.tx = (idx_q == 3'd0) ? fdp_pkg::BChAck : fdp_pkg::BChDone;
      end
      fdp_pkg::EV_PROG: begin
        if (idx_q == 3'd0) begin
          res.kind = fdp_pkg::KindProg;  res.addr = bd_q.addr;  res.data = bd_q.data;
        end else begin
          res.tx = fdp_pkg::BChDone;
        end
      end
      fdp_pkg::EV_EXIT: begin
        case (idx_q)
          3'd0: res.tx = fdp_pkg::BExitAck;
          3'd1: begin
            res.kind = fdp_pkg::KindErase;  res.sector = 3'd1;
          end
          3'd2: begin
            res.kind = fdp_pkg::KindProg;  res.addr = ctx_i.mark;
            res.data = ctx_i.first;
          end
          3'd3: begin
            res.kind = fdp_pkg::KindProg;  res.addr = ctx_i.mark + 32'd4;
            res.data = ctx_i.entry;
          end
          3'd4: begin
            res.kind = fdp_pkg::KindProg;  res.addr = ctx_i.mark + 32'd8;
            res.data = ctx_i.size;
          end
          default: res.kind = fdp_pkg::KindReset;
        endcase
      end
      default: begin
        res.tx = 8'd0;
      end
    endcase
  end

  assign valid_o = bv_q;
  assign last_o  = is_last;
  assign user_o  = res.kind;
  assign data_o  = {5'd0, res.data, res.addr, res.sector, res.tx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q  <= 1'b0;
      idx_q <= 3'd0;
    end else if (load_i) begin
      bv_q  <= 1'b1;
      idx_q <= 3'd0;
    end else if (take) begin
      if (is_last) bv_q <= 1'b0;
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) bd_q <= bundle_i;
  end

endmodule

`default_nettype wire

// ===== rtl/firmware_download_protocol_top.sv =====
// Top level of the firmware download engine: input register, configuration
// registers, protocol core and result drainer. Depends on fdp_pkg,
// fdp_core and fdp_drain.
//
// Usage
//  - Slave stream: one beat per poll tick or received link byte.
//    tuser = mode (0 poll, 1 byte), tdata = rx_byte.
//  - Master stream: one beat per result. tuser = kind (0 transmit, 1 erase,
//    2 program, 3 reset). tdata from bit 0 up: tx_byte[7:0], sector[10:8],
//    word_address[42:11], word_data[74:43], zero pad [79:75]. tlast marks
//    the final result of an input beat.
//  - Config: write cfg_we_i with cfg_idx_i 0 (update request word) or
//    1 (mark address); only while the engine is idle.
//  - Path: a beat accepted into the input register is decoded by the core and
//    loaded into the result register, which presents its first result.
//  - Throughput: the result register drains one result per cycle while tready
//    is high; a beat with n results (1 to 6) holds it until the last is taken,
//    beats without results need no slot. Single-result beats: one per cycle.
//  - Stall: while the receiver holds tready low the result holds; the input
//    register still takes a beat; tready drops while it holds one with results.
//  - Reset: session phase, request word 0xFFFFFFFF, mark address 0, both
//    stream stages empty.
`default_nettype none

module firmware_download_protocol_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // rx_byte
  input  wire logic        s_axis_tuser_i,   // mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [79:0]      m_axis_tdata_o,   // tx_byte, sector, word_address,
                                             // word_data, pad
  output logic [1:0]       m_axis_tuser_o,   // kind
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  logic        in_valid_q, in_mode_q;
  logic [7:0]  in_byte_q;
  logic [31:0] req_word_q, mark_q;
  logic        fire, load, free;
  fdp_pkg::bundle_t bundle;
  fdp_pkg::ctx_t    ctx;

  // input register frees as soon as the core consumes its beat
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_mode_q <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_word_q <= fdp_pkg::ReqWait;
      mark_q     <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdp_pkg::RegUpdateReq: req_word_q <= cfg_data_i;
        fdp_pkg::RegMark:      mark_q     <= cfg_data_i;
      endcase
    end
  end

  fdp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .in_mode_i  (in_mode_q),
    .in_byte_i  (in_byte_q),
    .req_word_i (req_word_q),
    .mark_i     (mark_q),
    .free_i     (free),
    .fire_o     (fire),
    .load_o     (load),
    .bundle_o   (bundle),
    .ctx_o      (ctx)
  );

  fdp_drain u_drain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .bundle_i (bundle),
    .ctx_i    (ctx),
    .free_o   (free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .data_o   (m_axis_tdata_o),
    .user_o   (m_axis_tuser_o),
    .last_o   (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== rtl/fdp_checker.sv =====
// Port-level checks for the firmware download engine, bound to the top.
// Depends on fdp_pkg and firmware_download_protocol_top.
`default_nettype none

module fdp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [79:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // reset request always closes its beat
  a_reset_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == fdp_pkg::KindReset |-> m_axis_tlast_o)
    else $error("reset request not last");

  // only sectors 1 to 5 are ever erased
  a_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == fdp_pkg::KindErase |->
      m_axis_tdata_o[10:8] == 3'd1 || m_axis_tdata_o[10:8] == 3'd2 ||
      m_axis_tdata_o[10:8] == 3'd3 || m_axis_tdata_o[10:8] == 3'd4 ||
      m_axis_tdata_o[10:8] == 3'd5)
    else $error("erase of unexpected sector");

  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != fdp_pkg::KindTx |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("tx byte set on non-transmit result");

endmodule

bind firmware_download_protocol_top fdp_checker u_fdp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
